FILE: design/dnat_pkg.sv
// Shared types and constants for the NAT binding table.
`default_nettype none
package dnat_pkg;
  localparam int PoolSize = 256;
  localparam int IdxW = 8;
  localparam int CntW = 9;

  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_OUT = 2'd1;
  localparam logic [1:0] KIND_IN = 2'd2;

  localparam logic [2:0] ST_HIT = 3'd0;
  localparam logic [2:0] ST_NEW = 3'd1;
  localparam logic [2:0] ST_REBOUND = 3'd2;
  localparam logic [2:0] ST_NOFREE = 3'd3;
  localparam logic [2:0] ST_NOREV = 3'd4;
  localparam logic [2:0] ST_TICK = 3'd5;

  localparam logic [1:0] REG_FIRST = 2'd0;
  localparam logic [1:0] REG_COUNT = 2'd1;
  localparam logic [1:0] REG_TTL = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [31:0] addr;
  } item_t;
endpackage
`default_nettype wire

FILE: design/dnat_ram.sv
// Generic simple dual-port RAM (one write, one read port) with registered read.
`default_nettype none
module dnat_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [$clog2(Depth)-1:0] waddr,
  input wire logic [Width-1:0] wdata,
  input wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: design/dnat_front.sv
// Front end: accepts items into a two-entry queue.
`default_nettype none
module dnat_front import dnat_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic [1:0] kind,
  input wire logic [31:0] addr,
  output logic busy,
  input wire logic pop,
  output logic q_valid,
  output item_t q_item
);
  item_t q [2];
  logic [1:0] cnt;
  logic push;
  assign busy = (cnt == 2'd2);
  assign push = start && !busy;
  assign q_valid = (cnt != 2'd0);
  assign q_item = q[0];
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, pop && q_valid};
    end
    if (pop && q_valid) begin
      // a new item lands in the head slot when the queue held only one
      if (push && cnt == 2'd1) q[0] <= '{kind: kind, addr: addr};
      else q[0] <= q[1];
    end else if (push) begin
      q[cnt[0]] <= '{kind: kind, addr: addr};
    end
  end
endmodule
`default_nettype wire

FILE: design/dnat_back.sv
// Back end: scans the pool and LRU order, updates bindings.
`default_nettype none
module dnat_back import dnat_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic cfg_we,
  input wire logic [1:0] cfg_idx,
  input wire logic [31:0] cfg_data,
  input wire logic q_valid,
  input item_t q_item,
  output logic pop,
  output logic done,
  output logic [2:0] status,
  output logic [31:0] mapped_addr,
  output logic [31:0] evicted_addr
);
  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_SCAN, S_LRU, S_VICT, S_LIVE, S_FIND, S_SHIFT, S_OUT
  } state_t;
  state_t state;

  logic [31:0] first_addr, ttl, now;
  logic [CntW-1:0] count;
  item_t it;
  logic [CntW-1:0] ptr;
  logic [IdxW-1:0] ent;
  logic [31:0] old_priv;

  logic bp_we, ex_we, lo_we;
  logic [IdxW-1:0] bp_wa, ex_wa, lo_wa, bp_ra, ex_ra, lo_ra;
  logic [31:0] bp_wd, ex_wd, bp_rd, ex_rd;
  logic [IdxW-1:0] lo_wd, lo_rd;
  logic [IdxW-1:0] shift_prev;
  logic rd_ok;

  dnat_ram #(.Width(32), .Depth(PoolSize)) u_bp (.clk, .we(bp_we), .waddr(bp_wa),
    .wdata(bp_wd), .raddr(bp_ra), .rdata(bp_rd));
  dnat_ram #(.Width(32), .Depth(PoolSize)) u_ex (.clk, .we(ex_we), .waddr(ex_wa),
    .wdata(ex_wd), .raddr(ex_ra), .rdata(ex_rd));
  dnat_ram #(.Width(IdxW), .Depth(PoolSize)) u_lo (.clk, .we(lo_we), .waddr(lo_wa),
    .wdata(lo_wd), .raddr(lo_ra), .rdata(lo_rd));

  logic [CntW-1:0] n;
  assign n = (count == '0) ? CntW'(1) : ((count > CntW'(PoolSize)) ? CntW'(PoolSize) : count);
  logic [31:0] rev_off;
  assign rev_off = it.addr - first_addr;
  logic [31:0] stamp_new;
  assign stamp_new = now + ttl;

  // lo reads ptr, bp ptr/ent (S_LIVE/S_VICT), ex ent; data lands next cycle.
  always_comb begin
    bp_ra = ptr[IdxW-1:0];
    ex_ra = ent;
    lo_ra = ptr[IdxW-1:0];
    if (state == S_LIVE || state == S_VICT) bp_ra = ent;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      ptr <= '0;
      first_addr <= '0;
      count <= CntW'(PoolSize);
      ttl <= 32'd600;
      now <= '0;
      done <= 1'b0;
      pop <= 1'b0;
      rd_ok <= 1'b0;
      bp_we <= 1'b0; ex_we <= 1'b0; lo_we <= 1'b0;
    end else begin
      done <= 1'b0;
      pop <= 1'b0;
      bp_we <= 1'b0; ex_we <= 1'b0; lo_we <= 1'b0;
      rd_ok <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_FIRST: first_addr <= cfg_data;
          REG_COUNT: count <= cfg_data[CntW-1:0];
          REG_TTL: ttl <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_INIT: begin
          // Clearing pass: free all entries, identity LRU order.
          bp_we <= 1'b1; bp_wa <= ptr[IdxW-1:0]; bp_wd <= '0;
          ex_we <= 1'b1; ex_wa <= ptr[IdxW-1:0]; ex_wd <= '0;
          lo_we <= 1'b1; lo_wa <= ptr[IdxW-1:0]; lo_wd <= ptr[IdxW-1:0];
          if (ptr == CntW'(PoolSize - 1)) begin
            ptr <= '0;
            state <= S_IDLE;
          end else ptr <= ptr + 1'b1;
        end
        S_IDLE: begin
          if (q_valid && !pop) begin
            it <= q_item;
            pop <= 1'b1;
            status <= ST_TICK; mapped_addr <= '0; evicted_addr <= '0;
            ptr <= '0;
            unique case (q_item.kind)
              KIND_TICK: begin now <= now + 1'b1; state <= S_OUT; end
              KIND_OUT: begin
                if (q_item.addr == '0) begin
                  status <= ST_NOFREE; state <= S_OUT;
                end else state <= S_SCAN;
              end
              KIND_IN: begin
                state <= S_VICT;
                ent <= IdxW'(q_item.addr - first_addr);
              end
              default: state <= S_OUT;
            endcase
          end
        end
        S_SCAN: begin
          // One entry per cycle; lowest index wins.
          if (rd_ok && bp_rd == it.addr) begin
            ent <= ptr[IdxW-1:0] - 1'b1;
            mapped_addr <= first_addr + 32'(ptr - 1'b1);
            status <= ST_HIT;
            if (!ttl[31]) begin
              ex_we <= 1'b1; ex_wa <= ptr[IdxW-1:0] - 1'b1; ex_wd <= stamp_new;
              ptr <= '0; state <= S_FIND;
            end else state <= S_OUT;
          end else if (ptr == n) begin
            if (rd_ok || n == '0) begin ptr <= '0; state <= S_LRU; end
          end else begin
            ptr <= ptr + 1'b1; rd_ok <= 1'b1;
          end
        end
        S_LRU: begin
          // First LRU position holding an entry below the count.
          if (rd_ok && CntW'(lo_rd) < n) begin
            ent <= lo_rd; state <= S_LIVE;
          end else begin
            ptr <= ptr + 1'b1; rd_ok <= 1'b1;
          end
        end
        S_LIVE: begin
          if (!rd_ok) rd_ok <= 1'b1;
          else begin
            if (bp_rd != '0 && (now - ex_rd) >= 32'h8000_0000) begin
              status <= ST_NOFREE; state <= S_OUT;
            end else begin
              status <= (bp_rd != '0) ? ST_REBOUND : ST_NEW;
              evicted_addr <= bp_rd;
              bp_we <= 1'b1; bp_wa <= ent; bp_wd <= it.addr;
              ex_we <= 1'b1; ex_wa <= ent; ex_wd <= stamp_new;
              mapped_addr <= first_addr + 32'(ent);
              ptr <= '0; state <= S_FIND;
            end
          end
        end
        S_VICT: begin
          // Reverse lookup: entry index known from the address.
          if (!rd_ok) rd_ok <= 1'b1;
          else if (rev_off < 32'(n) && bp_rd != '0) begin
            status <= ST_HIT; mapped_addr <= bp_rd;
            if (!ttl[31]) begin
              ex_we <= 1'b1; ex_wa <= ent; ex_wd <= stamp_new;
              ptr <= '0; state <= S_FIND;
            end else state <= S_OUT;
          end else begin
            status <= ST_NOREV; state <= S_OUT;
          end
        end
        S_FIND: begin
          // Locate ent in the LRU order.
          if (rd_ok && lo_rd == ent) begin
            state <= S_SHIFT; rd_ok <= 1'b1; ptr <= ptr + 1'b1;
          end else begin
            ptr <= ptr + 1'b1; rd_ok <= 1'b1;
          end
        end
        S_SHIFT: begin
          // Data read at ptr - 1 lands at position ptr - 2; tail written last.
          if (ptr == CntW'(PoolSize + 1)) begin
            lo_we <= 1'b1; lo_wa <= IdxW'(PoolSize - 1); lo_wd <= ent;
            state <= S_OUT;
          end else if (rd_ok) begin
            lo_we <= 1'b1; lo_wa <= shift_prev; lo_wd <= lo_rd;
            ptr <= ptr + 1'b1; rd_ok <= 1'b1;
          end else begin
            ptr <= ptr + 1'b1; rd_ok <= 1'b1;
          end
        end
        S_OUT: begin
          done <= 1'b1; ptr <= '0; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) shift_prev <= ptr[IdxW-1:0] - 1'b1;
endmodule
`default_nettype wire

FILE: design/dynamic_nat_binding_table.sv
// Top level of the NAT binding table.
// Items are taken while busy is low into a two-entry queue; each yields one result
// with done high for one cycle, and the receiver cannot stall results. A tick, a
// zero-address outbound item or an unused kind goes from S_IDLE straight to S_OUT;
// a reverse lookup first reads its entry in S_VICT. Longer items are set by
// memory walks through one read port each: an outbound item scans the first
// pool_count binding entries, on a miss searches the LRU order from its head
// for the first entry below the count, and whenever an entry moves to the LRU
// tail walks all 256 LRU positions. An inbound hit that refreshes walks them too.
// After reset a clearing pass over all 256 entries runs before items are processed.
`default_nettype none
module dynamic_nat_binding_table import dnat_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  output logic busy,
  input wire logic [1:0] kind,
  input wire logic [31:0] addr,
  input wire logic cfg_we,
  input wire logic [1:0] cfg_idx,
  input wire logic [31:0] cfg_data,
  output logic done,
  output logic [2:0] status,
  output logic [31:0] mapped_addr,
  output logic [31:0] evicted_addr
);
  logic pop, q_valid;
  item_t q_item;
  dnat_front u_front (.clk, .rst, .start, .kind, .addr, .busy, .pop, .q_valid, .q_item);
  dnat_back u_back (.clk, .rst, .cfg_we, .cfg_idx, .cfg_data, .q_valid, .q_item, .pop,
    .done, .status, .mapped_addr, .evicted_addr);
endmodule
`default_nettype wire

FILE: design/dnat_checker.sv
// Port-level checks for the NAT binding table.
`default_nettype none
module dnat_props import dnat_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic done,
  input wire logic [2:0] status,
  input wire logic [31:0] mapped_addr,
  input wire logic [31:0] evicted_addr
);
  a_st: assert property (@(posedge clk) disable iff (rst) done |-> status <= ST_TICK)
    else $error("bad status");
  a_ev: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_REBOUND |-> evicted_addr == '0) else $error("evicted");
  a_map: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_NOFREE || status == ST_NOREV || status == ST_TICK)
    |-> mapped_addr == '0) else $error("mapped");
  a_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done");
endmodule
bind dynamic_nat_binding_table dnat_props u_chk (.clk, .rst, .done, .status,
  .mapped_addr, .evicted_addr);
`default_nettype wire

FILE: dv/dnat_checker.sv
// Checker for the NAT binding table: predicts each result and compares it.
`timescale 1ns / 1ps
module dnat_checker import dnat_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic [1:0] kind,
  input wire logic [31:0] addr,
  input wire logic cfg_we,
  input wire logic [1:0] cfg_idx,
  input wire logic [31:0] cfg_data,
  input wire logic done,
  input wire logic [2:0] status,
  input wire logic [31:0] mapped_addr,
  input wire logic [31:0] evicted_addr,
  output int fail_count,
  output int pending_count,
  output int hit_count,
  output int rebound_count,
  output int nofree_count
);
  typedef struct packed {
    logic [2:0] status;
    logic [31:0] mapped;
    logic [31:0] evicted;
  } nat_result_t;

  logic [31:0] first_addr;
  logic [8:0] count_reg;
  logic [31:0] ttl;
  logic [31:0] bound [PoolSize];
  logic [31:0] stamp [PoolSize];
  int lru [PoolSize];
  logic [31:0] now;
  nat_result_t expected_q[$];

  assign pending_count = expected_q.size();

  function automatic bit entry_live(int e);
    logic [31:0] d;
    d = now - stamp[e];
    return bound[e] != 0 && d[31];
  endfunction

  function automatic void to_lru_tail(int e);
    int p;
    p = 0;
    while (p < PoolSize && lru[p] != e) p++;
    for (int i = p; i < PoolSize - 1; i++) lru[i] = lru[i + 1];
    lru[PoolSize - 1] = e;
  endfunction

  function automatic void refresh_entry(int e);
    if (!ttl[31]) begin
      stamp[e] = now + ttl;
      to_lru_tail(e);
    end
  endfunction

  function automatic nat_result_t translate(logic [1:0] k, logic [31:0] a);
    nat_result_t r;
    int n, e, p;
    logic [31:0] off;
    r = '{ST_TICK, 32'd0, 32'd0};
    n = (count_reg == 0) ? 1 : (count_reg > PoolSize ? PoolSize : int'(count_reg));
    if (k == KIND_TICK) begin
      now = now + 1;
    end else if (k == KIND_OUT) begin
      if (a == 0) begin
        r.status = ST_NOFREE;
      end else begin
        for (e = 0; e < n; e++) if (bound[e] == a) break;
        if (e < n) begin
          refresh_entry(e);
          r.status = ST_HIT;
          r.mapped = first_addr + e;
        end else begin
          p = 0;
          while (p < PoolSize && lru[p] >= n) p++;
          e = (p < PoolSize) ? lru[p] : 0;
          if (entry_live(e)) begin
            r.status = ST_NOFREE;
          end else begin
            if (bound[e] != 0) begin
              r.status = ST_REBOUND;
              r.evicted = bound[e];
            end else begin
              r.status = ST_NEW;
            end
            bound[e] = a;
            stamp[e] = now + ttl;
            to_lru_tail(e);
            r.mapped = first_addr + e;
          end
        end
      end
    end else if (k == KIND_IN) begin
      off = a - first_addr;
      if (off < n && bound[off[7:0]] != 0) begin
        refresh_entry(int'(off));
        r.status = ST_HIT;
        r.mapped = bound[off[7:0]];
      end else begin
        r.status = ST_NOREV;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    nat_result_t got, want;
    if (rst) begin
      first_addr = 0;
      count_reg = 9'd256;
      ttl = 32'd600;
      now = 0;
      for (int i = 0; i < PoolSize; i++) begin
        bound[i] = 0;
        stamp[i] = 0;
        lru[i] = i;
      end
      expected_q.delete();
      fail_count = 0;
      hit_count = 0;
      rebound_count = 0;
      nofree_count = 0;
    end else begin
      // result first: it was produced from items accepted earlier
      if (done) begin
        got = '{status, mapped_addr, evicted_addr};
        if (expected_q.size() == 0) begin
          $error("result with nothing expected: status %0d", status);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (got.status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
          end
          if (got.mapped != want.mapped) begin
            $error("mapped_addr: expected %h, got %h", want.mapped, got.mapped);
            fail_count++;
          end
          if (got.evicted != want.evicted) begin
            $error("evicted_addr: expected %h, got %h", want.evicted, got.evicted);
            fail_count++;
          end
          if (want.status == ST_HIT) hit_count++;
          if (want.status == ST_REBOUND) rebound_count++;
          if (want.status == ST_NOFREE) nofree_count++;
        end
      end
      if (cfg_we) begin
        case (cfg_idx)
          REG_FIRST: first_addr = cfg_data;
          REG_COUNT: count_reg = cfg_data[8:0];
          REG_TTL: ttl = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) expected_q.push_back(translate(kind, addr));
    end
  end
endmodule

FILE: dv/dynamic_nat_binding_table_tb.sv
// Testbench top for the NAT binding table: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module dynamic_nat_binding_table_tb import dnat_pkg::*;;
  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [1:0] kind;
  logic [31:0] addr;
  logic cfg_we;
  logic [1:0] cfg_idx;
  logic [31:0] cfg_data;
  logic done;
  logic [2:0] status;
  logic [31:0] mapped_addr;
  logic [31:0] evicted_addr;
  int fail_count, pending_count, hit_count, rebound_count, nofree_count;
  int items_sent;
  int idle_cycles;
  bit quiet_gaps;
  logic [31:0] first_now;
  logic [8:0] count_now;
  logic [31:0] priv_set [8];

  localparam int WatchdogLimit = 20000;

  dynamic_nat_binding_table i_dut (
    .clk, .rst, .start, .busy, .kind, .addr, .cfg_we, .cfg_idx, .cfg_data,
    .done, .status, .mapped_addr, .evicted_addr
  );

  dnat_checker i_checker (
    .clk, .rst, .start, .busy, .kind, .addr, .cfg_we, .cfg_idx, .cfg_data,
    .done, .status, .mapped_addr, .evicted_addr,
    .fail_count, .pending_count, .hit_count, .rebound_count, .nofree_count
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // counts cycles without any accepted item or result
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // start stays high into the next item when there is no gap
  task automatic send_item(logic [1:0] k, logic [31:0] a);
    while (!quiet_gaps && $urandom_range(99) < 20) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    kind <= k;
    addr <= a;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FIRST) first_now = data;
    if (idx == REG_COUNT) count_now = data[8:0];
  endtask

  // random item biased toward a small working set of private addresses
  task automatic random_item();
    int r;
    logic [31:0] span;
    r = $urandom_range(99);
    span = (count_now == 0) ? 1 : count_now;
    if (r < 15) send_item(KIND_TICK, $urandom);
    else if (r < 55) send_item(KIND_OUT, priv_set[$urandom_range(7)]);
    else if (r < 65) send_item(KIND_OUT, $urandom);
    else if (r < 90) send_item(KIND_IN, first_now + $urandom_range(span));
    else if (r < 95) send_item(KIND_IN, $urandom);
    else send_item(2'd3, $urandom);
  endtask

  initial begin
    rst = 1;
    start = 0;
    kind = KIND_TICK;
    addr = 0;
    cfg_we = 0;
    cfg_idx = REG_FIRST;
    cfg_data = 0;
    items_sent = 0;
    quiet_gaps = 0;
    first_now = 0;
    count_now = 9'd256;
    for (int i = 0; i < 8; i++) priv_set[i] = $urandom | 32'h1;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: small pool, short ttl, extremes of fields
    write_reg(REG_FIRST, 32'hFFFF_FFFE);
    write_reg(REG_COUNT, 9'd2);
    write_reg(REG_TTL, 32'd2);
    send_item(KIND_OUT, 32'h0);
    send_item(KIND_OUT, 32'hFFFF_FFFF);
    send_item(KIND_OUT, 32'h1);
    send_item(KIND_OUT, 32'h5);
    send_item(KIND_OUT, 32'hFFFF_FFFF);
    send_item(KIND_IN, 32'hFFFF_FFFE);
    send_item(KIND_IN, 32'hFFFF_FFFF);
    send_item(KIND_IN, 32'h0);
    send_item(KIND_IN, 32'h1234_5678);
    send_item(KIND_TICK, 32'hFFFF_FFFF);
    send_item(KIND_TICK, 32'h0);
    send_item(KIND_TICK, 32'h0);
    send_item(KIND_IN, 32'hFFFF_FFFF);
    send_item(KIND_OUT, 32'h5);
    send_item(KIND_OUT, 32'h7);
    send_item(2'd3, 32'hA5A5_A5A5);
    wait_drained();
    // negative ttl: new bindings born expired, hits do not refresh
    write_reg(REG_TTL, 32'hFFFF_FFFF);
    write_reg(REG_COUNT, 9'd0);
    send_item(KIND_OUT, 32'h9);
    send_item(KIND_OUT, 32'hA);
    send_item(KIND_IN, 32'hFFFF_FFFE);
    wait_drained();
    // count above pool size; entries beyond old count are stale
    write_reg(REG_COUNT, 9'h1FF);
    send_item(KIND_OUT, 32'hA);
    send_item(KIND_OUT, 32'h5);
    wait_drained();

    // random phases across register settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(REG_COUNT, 9'd4); write_reg(REG_TTL, 32'd3); end
        1: begin write_reg(REG_FIRST, $urandom); write_reg(REG_COUNT, 9'd1); end
        2: begin write_reg(REG_TTL, 32'h7FFF_FFFF); write_reg(REG_COUNT, 9'd6); end
        3: begin write_reg(REG_TTL, 32'd0); write_reg(REG_COUNT, 9'd256); end
        4: begin write_reg(REG_TTL, 32'hFFFF_FFFF); write_reg(REG_COUNT, 9'd5); end
        default: begin
          write_reg(REG_FIRST, 32'h0); write_reg(REG_TTL, 32'd5);
          write_reg(REG_COUNT, 9'd8);
        end
      endcase
      for (int i = 0; i < 8; i++)
        if ($urandom_range(2) == 0) priv_set[i] = $urandom_range(1) ? $urandom : 32'h1 << i;
      quiet_gaps = (ph == 2);
      for (int i = 0; i < 145; i++) random_item();
      wait_drained();
    end

    $display("Covered %0d items: %0d hits, %0d rebinds, %0d no-free answers,",
             items_sent, hit_count, rebound_count, nofree_count);
    $display("pool sizes 1 to 256, ttl negative, zero, small and maximal.");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
